// ===== sv/source_line_classifier_defines.svh =====
// assertion macros for the source line classifier
// expects aclk and aresetn in the scope where a macro is used
`ifndef SOURCE_LINE_CLASSIFIER_DEFINES_SVH
`define SOURCE_LINE_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define SLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/slc_pkg.sv =====
// shared types, constants and helper functions of the source line classifier
// no dependencies
package slc_pkg;

    localparam int MAX_DELIMITER_DEF = 6;
    localparam int COUNT_BITS_DEF    = 32;

    localparam int PAT_BYTES   = 6;
    localparam int PAT_W       = 8 * PAT_BYTES;
    localparam int LEN_W       = 3;
    localparam int SKIP_W      = 3;
    localparam int OUT_W       = 32;
    localparam int CFG_INDEX_W = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_OPEN_PATTERN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_OPEN_LENGTH    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_CLOSE_PATTERN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_CLOSE_LENGTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMMENT_PATTERN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMMENT_LENGTH  = 3'd5;

    // scanner modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_LINE   = 2'd2;
    localparam logic [1:0] MODE_BLOCK  = 2'd3;

    // character codes
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
    localparam logic [7:0] CHAR_SLASH     = 8'h2f;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_VTAB      = 8'h0b;
    localparam logic [7:0] CHAR_FORMFEED  = 8'h0c;
    localparam logic [7:0] CHAR_RETURN    = 8'h0d;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] code_lines;
        logic [OUT_W-1:0] comment_lines;
        logic [OUT_W-1:0] blank_lines;
    } out_item_t;

    typedef struct packed {
        logic [PAT_W-1:0] block_open_pattern;
        logic [LEN_W-1:0] block_open_length;
        logic [PAT_W-1:0] block_close_pattern;
        logic [LEN_W-1:0] block_close_length;
        logic [PAT_W-1:0] line_comment_pattern;
        logic [LEN_W-1:0] line_comment_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic              has_code;
        logic              has_comment;
        logic              seen;
        logic [SKIP_W-1:0] skip;
        logic [7:0]        prev;
    } scan_state_t;

    typedef struct packed {
        logic code;
        logic comment;
        logic blank;
    } bump_t;

    localparam cfg_t CFG_RESET = '{
        block_open_pattern:   48'd10799,
        block_open_length:    3'd2,
        block_close_pattern:  48'd12074,
        block_close_length:   3'd2,
        line_comment_pattern: 48'd12079,
        line_comment_length:  3'd2
    };

    localparam scan_state_t SCAN_RESET = '{
        mode:        MODE_NORMAL,
        has_code:    1'b0,
        has_comment: 1'b0,
        seen:        1'b0,
        skip:        3'd0,
        prev:        8'd0
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE) ||
               (c == CHAR_VTAB) || (c == CHAR_FORMFEED) || (c == CHAR_RETURN);
    endfunction

    // which total a finished line goes to
    function automatic bump_t line_bump(input scan_state_t st);
        bump_t b;
        b = '0;
        if (st.seen) begin
            if (st.has_code) begin
                b.code = 1'b1;
            end else if (st.has_comment) begin
                b.comment = 1'b1;
            end else begin
                b.blank = 1'b1;
            end
        end
        return b;
    endfunction

endpackage

// ===== sv/slc_head_step.sv =====
// examines or skips the head byte of the lookahead window
// depends on slc_pkg
module slc_head_step
    import slc_pkg::*;
#(
    parameter int MAX_DELIMITER = MAX_DELIMITER_DEF
) (
    input  logic [MAX_DELIMITER-1:0][7:0]          window,
    input  logic [$clog2(MAX_DELIMITER+1)-1:0]     avail,
    input  cfg_t                                   cfg,
    input  scan_state_t                            cur,
    output scan_state_t                            nxt,
    output bump_t                                  bump
);

    localparam int AVAIL_W   = $clog2(MAX_DELIMITER + 1);
    localparam int CMP_BYTES = (MAX_DELIMITER < PAT_BYTES) ? MAX_DELIMITER : PAT_BYTES;

    function automatic logic delim_match(
        input logic [PAT_W-1:0]              pat,
        input logic [LEN_W-1:0]              len,
        input logic [MAX_DELIMITER-1:0][7:0] win,
        input logic [AVAIL_W-1:0]            av
    );
        logic hit;
        hit = (len != '0) && (int'(len) <= PAT_BYTES) && (int'(len) <= MAX_DELIMITER) &&
              (int'(len) <= int'(av));
        for (int k = 0; k < CMP_BYTES; k++) begin
            if ((k < int'(len)) && (win[k] != pat[8*k +: 8])) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    logic       open_hit;
    logic       line_hit;
    logic       close_hit;
    logic [7:0] c;

    assign open_hit  = delim_match(cfg.block_open_pattern, cfg.block_open_length, window, avail);
    assign line_hit  = delim_match(cfg.line_comment_pattern, cfg.line_comment_length,
                                   window, avail);
    assign close_hit = delim_match(cfg.block_close_pattern, cfg.block_close_length,
                                   window, avail);
    assign c = window[0];

    always_comb begin
        nxt  = cur;
        bump = '0;
        if (cur.skip != '0) begin
            nxt.skip = cur.skip - SKIP_W'(1);
        end else begin
            nxt.prev = c;
            nxt.seen = 1'b1;
            case (cur.mode)
                MODE_NORMAL: begin
                    if (open_hit) begin
                        nxt.has_comment = 1'b1;
                        nxt.mode        = MODE_BLOCK;
                        nxt.skip        = SKIP_W'(cfg.block_open_length - LEN_W'(1));
                    end else if (line_hit) begin
                        nxt.has_comment = 1'b1;
                        nxt.mode        = MODE_LINE;
                        nxt.skip        = SKIP_W'(cfg.line_comment_length - LEN_W'(1));
                    end else if (c == CHAR_QUOTE) begin
                        nxt.has_code = 1'b1;
                        nxt.mode     = MODE_STRING;
                    end else if (c == CHAR_NEWLINE) begin
                        bump            = line_bump(cur);
                        nxt.has_code    = 1'b0;
                        nxt.has_comment = 1'b0;
                    end else if (!is_space(c) && (c != CHAR_SLASH)) begin
                        nxt.has_code = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if ((c == CHAR_QUOTE) && (cur.prev != CHAR_BACKSLASH)) begin
                        nxt.mode = MODE_NORMAL;
                    end else if (c == CHAR_NEWLINE) begin
                        bump            = line_bump(cur);
                        nxt.has_comment = 1'b0;
                        nxt.has_code    = 1'b1;
                    end
                end
                MODE_LINE: begin
                    if (c == CHAR_NEWLINE) begin
                        bump            = line_bump(cur);
                        nxt.has_code    = 1'b0;
                        nxt.has_comment = 1'b0;
                        nxt.mode        = MODE_NORMAL;
                    end
                end
                default: begin
                    if (close_hit) begin
                        nxt.mode = MODE_NORMAL;
                        nxt.skip = SKIP_W'(cfg.block_close_length - LEN_W'(1));
                    end else if (c == CHAR_NEWLINE) begin
                        bump            = line_bump(cur);
                        nxt.has_code    = 1'b0;
                        nxt.has_comment = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// ===== sv/source_line_classifier.sv =====
// top level of the source line classifier: window, totals, config and result register
// depends on slc_pkg, slc_head_step and source_line_classifier_defines.svh
//
// Takes a source file one byte per cycle while s_ready is high and classifies each line
// as code, comment or blank; on the byte marked final_byte one transaction with the three
// totals is given and the block starts over with a new file, keeping its configuration.
// Bytes wait in a lookahead window of MAX_DELIMITER entries so that delimiters are
// matched in parallel; while no final byte arrives a byte is taken every cycle. After the
// final byte the window drains through the single head-step unit, one byte a cycle,
// and then the totals are formed into the result register; s_ready stays low through
// the drain and while the previous file's result still waits to be taken. The result
// sits in an output register, so a new file may start while the previous result waits
// to be taken.
`include "source_line_classifier_defines.svh"

module source_line_classifier
    import slc_pkg::*;
#(
    parameter int MAX_DELIMITER = MAX_DELIMITER_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PAT_W-1:0]       cfg_wr_data
);

    localparam int FILL_W = $clog2(MAX_DELIMITER + 1);

    typedef logic [MAX_DELIMITER-1:0][7:0] window_t;

    cfg_t                  cfg_reg,           cfg_next;
    scan_state_t           scan_reg,          scan_next;
    window_t               win_reg,           win_next;
    logic [FILL_W-1:0]     fill_reg,          fill_next;
    logic                  flush_reg,         flush_next;
    logic [COUNT_BITS-1:0] code_total_reg,    code_total_next;
    logic [COUNT_BITS-1:0] comment_total_reg, comment_total_next;
    logic [COUNT_BITS-1:0] blank_total_reg,   blank_total_next;
    logic                  m_valid_reg,       m_valid_next;
    out_item_t             m_data_reg,        m_data_next;

    window_t               win_app;
    window_t               step_win;
    window_t               win_shift;
    logic [FILL_W-1:0]     step_avail;
    scan_state_t           step_nxt;
    bump_t                 step_bump;
    bump_t                 fin_bump;
    bump_t                 bump_sel;
    logic                  s_fire;
    logic                  finalize;
    logic                  clear;
    logic [COUNT_BITS-1:0] code_inc;
    logic [COUNT_BITS-1:0] comment_inc;
    logic [COUNT_BITS-1:0] blank_inc;
    logic [OUT_W-1:0]      code_out;
    logic [OUT_W-1:0]      comment_out;
    logic [OUT_W-1:0]      blank_out;

    assign s_ready  = !flush_reg;
    assign s_fire   = s_valid && s_ready;
    assign finalize = flush_reg && (fill_reg == '0) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // incoming byte lands behind the bytes already waiting
    always_comb begin
        win_app = win_reg;
        for (int i = 0; i < MAX_DELIMITER; i++) begin
            if (fill_reg == FILL_W'(i)) begin
                win_app[i] = s_data.text_byte;
            end
        end
    end

    assign step_win   = flush_reg ? win_reg : win_app;
    assign step_avail = flush_reg ? fill_reg : FILL_W'(MAX_DELIMITER);

    always_comb begin
        win_shift = step_win;
        for (int i = 0; i < MAX_DELIMITER - 1; i++) begin
            win_shift[i] = step_win[i+1];
        end
    end

    slc_head_step #(
        .MAX_DELIMITER (MAX_DELIMITER)
    ) u_head_step (
        .window (step_win),
        .avail  (step_avail),
        .cfg    (cfg_reg),
        .cur    (scan_reg),
        .nxt    (step_nxt),
        .bump   (step_bump)
    );

    // last line counts unless the last examined byte ended it
    assign fin_bump = (scan_reg.prev != CHAR_NEWLINE) ? line_bump(scan_reg) : bump_t'('0);

    always_comb begin
        scan_next  = scan_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        flush_next = flush_reg;
        bump_sel   = '0;
        clear      = 1'b0;
        if (s_fire) begin
            if (s_data.final_byte) begin
                win_next   = win_app;
                fill_next  = fill_reg + FILL_W'(1);
                flush_next = 1'b1;
            end else if (fill_reg == FILL_W'(MAX_DELIMITER - 1)) begin
                scan_next = step_nxt;
                bump_sel  = step_bump;
                win_next  = win_shift;
            end else begin
                win_next  = win_app;
                fill_next = fill_reg + FILL_W'(1);
            end
        end else if (flush_reg && (fill_reg != '0)) begin
            scan_next = step_nxt;
            bump_sel  = step_bump;
            win_next  = win_shift;
            fill_next = fill_reg - FILL_W'(1);
        end else if (finalize) begin
            bump_sel   = fin_bump;
            clear      = 1'b1;
            flush_next = 1'b0;
            scan_next  = SCAN_RESET;
        end
    end

    // saturating totals
    assign code_inc = (bump_sel.code && (code_total_reg != '1)) ?
                      code_total_reg + COUNT_BITS'(1) : code_total_reg;
    assign comment_inc = (bump_sel.comment && (comment_total_reg != '1)) ?
                         comment_total_reg + COUNT_BITS'(1) : comment_total_reg;
    assign blank_inc = (bump_sel.blank && (blank_total_reg != '1)) ?
                       blank_total_reg + COUNT_BITS'(1) : blank_total_reg;

    assign code_total_next    = clear ? '0 : code_inc;
    assign comment_total_next = clear ? '0 : comment_inc;
    assign blank_total_next   = clear ? '0 : blank_inc;

    generate
        if (COUNT_BITS > OUT_W) begin : g_out_sat
            assign code_out    = (|code_inc[COUNT_BITS-1:OUT_W]) ? '1 : code_inc[OUT_W-1:0];
            assign comment_out = (|comment_inc[COUNT_BITS-1:OUT_W]) ? '1 :
                                 comment_inc[OUT_W-1:0];
            assign blank_out   = (|blank_inc[COUNT_BITS-1:OUT_W]) ? '1 : blank_inc[OUT_W-1:0];
        end else begin : g_out_ext
            assign code_out    = OUT_W'(code_inc);
            assign comment_out = OUT_W'(comment_inc);
            assign blank_out   = OUT_W'(blank_inc);
        end
    endgenerate

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (finalize) begin
            m_valid_next              = 1'b1;
            m_data_next.code_lines    = code_out;
            m_data_next.comment_lines = comment_out;
            m_data_next.blank_lines   = blank_out;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_BLOCK_OPEN_PATTERN:   cfg_next.block_open_pattern   = cfg_wr_data;
                REG_BLOCK_OPEN_LENGTH:    cfg_next.block_open_length    = cfg_wr_data[LEN_W-1:0];
                REG_BLOCK_CLOSE_PATTERN:  cfg_next.block_close_pattern  = cfg_wr_data;
                REG_BLOCK_CLOSE_LENGTH:   cfg_next.block_close_length   = cfg_wr_data[LEN_W-1:0];
                REG_LINE_COMMENT_PATTERN: cfg_next.line_comment_pattern = cfg_wr_data;
                REG_LINE_COMMENT_LENGTH:  cfg_next.line_comment_length  = cfg_wr_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg           <= CFG_RESET;
            scan_reg          <= SCAN_RESET;
            fill_reg          <= '0;
            flush_reg         <= 1'b0;
            code_total_reg    <= '0;
            comment_total_reg <= '0;
            blank_total_reg   <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            cfg_reg           <= cfg_next;
            scan_reg          <= scan_next;
            fill_reg          <= fill_next;
            flush_reg         <= flush_next;
            code_total_reg    <= code_total_next;
            comment_total_reg <= comment_total_next;
            blank_total_reg   <= blank_total_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg    <= win_next;
        m_data_reg <= m_data_next;
    end

    `SLC_ASSERT_NEXT(a_final_starts_drain, s_fire && s_data.final_byte, flush_reg, "final byte did not start drain")
    `SLC_ASSERT_NOW(a_fill_bound, !flush_reg, fill_reg <= FILL_W'(MAX_DELIMITER - 1), "window overfilled while streaming")
    `SLC_ASSERT_NOW(a_result_from_drain, $rose(m_valid_reg), $past(flush_reg) && !flush_reg, "result without drain")
    `SLC_ASSERT_NOW(a_string_no_skip, scan_reg.mode == MODE_STRING, scan_reg.skip == '0, "skip pending in string mode")

endmodule

// ===== sim/source_line_classifier_tb.sv =====
// self-checking testbench for source_line_classifier: random and directed source files,
// line totals predicted per file and checked against each result transaction
// depends on slc_pkg and the source_line_classifier rtl
`timescale 1ns / 100ps

module source_line_classifier_tb;
    import slc_pkg::*;

    localparam int WINDOW        = MAX_DELIMITER_DEF;
    localparam int PHASE_BYTES   = 235;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 250;
    localparam int STALL_LIMIT   = 5000;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    class line_tally_board;
        cfg_t             regs;
        logic [1:0]       mode;
        logic             has_code;
        logic             has_comment;
        logic             seen;
        logic [7:0]       win [WINDOW];
        int               fill;
        int               skip;
        logic [7:0]       prev;
        logic [OUT_W-1:0] code_total;
        logic [OUT_W-1:0] comment_total;
        logic [OUT_W-1:0] blank_total;
        out_item_t        totals_due [$];
        int               mismatches;

        function new();
            regs = CFG_RESET;
            mismatches = 0;
            restart_file();
        endfunction

        function void restart_file();
            mode = MODE_NORMAL;
            has_code = 1'b0;
            has_comment = 1'b0;
            seen = 1'b0;
            foreach (win[k]) win[k] = 8'd0;
            fill = 0;
            skip = 0;
            prev = 8'd0;
            code_total = '0;
            comment_total = '0;
            blank_total = '0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [PAT_W-1:0] data);
            case (idx)
                REG_BLOCK_OPEN_PATTERN:   regs.block_open_pattern = data;
                REG_BLOCK_OPEN_LENGTH:    regs.block_open_length = data[LEN_W-1:0];
                REG_BLOCK_CLOSE_PATTERN:  regs.block_close_pattern = data;
                REG_BLOCK_CLOSE_LENGTH:   regs.block_close_length = data[LEN_W-1:0];
                REG_LINE_COMMENT_PATTERN: regs.line_comment_pattern = data;
                REG_LINE_COMMENT_LENGTH:  regs.line_comment_length = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return totals_due.size();
        endfunction

        function bit blank_char(logic [7:0] c);
            return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_RETURN);
        endfunction

        function void count_line();
            if (!seen) return;
            if (has_code) begin
                if (code_total != '1) code_total++;
            end else if (has_comment) begin
                if (comment_total != '1) comment_total++;
            end else begin
                if (blank_total != '1) blank_total++;
            end
        endfunction

        function bit at_head(logic [PAT_W-1:0] pat, logic [LEN_W-1:0] len, int avail);
            int k;
            if (len == 0 || len > PAT_BYTES || len > WINDOW || len > avail) return 1'b0;
            for (k = 0; k < len; k++) begin
                if (win[k] != pat[8*k +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // classify or skip the oldest byte of the window, then drop it
        function void retire_head();
            logic [7:0] c;
            logic [7:0] lc;
            int avail;
            int k;
            avail = fill;
            if (avail == 0) return;
            if (skip > 0) begin
                skip--;
            end else begin
                c = win[0];
                lc = prev;
                prev = c;
                case (mode)
                    MODE_NORMAL: begin
                        if (at_head(regs.block_open_pattern, regs.block_open_length, avail)) begin
                            has_comment = 1'b1;
                            mode = MODE_BLOCK;
                            skip = int'(regs.block_open_length) - 1;
                        end else if (at_head(regs.line_comment_pattern,
                                             regs.line_comment_length, avail)) begin
                            has_comment = 1'b1;
                            mode = MODE_LINE;
                            skip = int'(regs.line_comment_length) - 1;
                        end else if (c == CHAR_QUOTE) begin
                            has_code = 1'b1;
                            mode = MODE_STRING;
                        end else if (c == CHAR_NEWLINE) begin
                            count_line();
                            has_code = 1'b0;
                            has_comment = 1'b0;
                        end else if (!blank_char(c) && c != CHAR_SLASH) begin
                            has_code = 1'b1;
                        end
                    end
                    MODE_STRING: begin
                        if (c == CHAR_QUOTE && lc != CHAR_BACKSLASH) begin
                            mode = MODE_NORMAL;
                        end else if (c == CHAR_NEWLINE) begin
                            count_line();
                            has_comment = 1'b0;
                            has_code = 1'b1;
                        end
                    end
                    MODE_LINE: begin
                        if (c == CHAR_NEWLINE) begin
                            count_line();
                            has_code = 1'b0;
                            has_comment = 1'b0;
                            mode = MODE_NORMAL;
                        end
                    end
                    default: begin
                        if (at_head(regs.block_close_pattern, regs.block_close_length, avail)) begin
                            mode = MODE_NORMAL;
                            skip = int'(regs.block_close_length) - 1;
                        end else if (c == CHAR_NEWLINE) begin
                            count_line();
                            has_code = 1'b0;
                            has_comment = 1'b1;
                        end
                    end
                endcase
                seen = 1'b1;
            end
            for (k = 0; k < WINDOW - 1; k++) win[k] = win[k+1];
            fill = avail - 1;
        endfunction

        function void take_byte(in_item_t item);
            out_item_t totals;
            if (fill >= WINDOW) retire_head();
            win[fill] = item.text_byte;
            fill++;
            if (!item.final_byte) begin
                if (fill >= WINDOW) retire_head();
                return;
            end
            while (fill > 0) retire_head();
            if (prev != CHAR_NEWLINE) count_line();
            totals.code_lines = code_total;
            totals.comment_lines = comment_total;
            totals.blank_lines = blank_total;
            totals_due.push_back(totals);
            restart_file();
        endfunction

        function void note_mismatch(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch in %s: expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void compare_totals(out_item_t got);
            out_item_t want;
            if (totals_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected transaction: code %0d comment %0d blank %0d",
                             $time, got.code_lines, got.comment_lines, got.blank_lines);
                return;
            end
            want = totals_due.pop_front();
            if (got.code_lines != want.code_lines)
                note_mismatch("code_lines", want.code_lines, got.code_lines);
            if (got.comment_lines != want.comment_lines)
                note_mismatch("comment_lines", want.comment_lines, got.comment_lines);
            if (got.blank_lines != want.blank_lines)
                note_mismatch("blank_lines", want.blank_lines, got.blank_lines);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [PAT_W-1:0]       cfg_wr_data;

    line_tally_board board;
    int bytes_sent   = 0;
    int quiet_cycles = 0;
    bit full_rate    = 1'b0;
    bit hold_request = 1'b0;

    source_line_classifier u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.take_byte(s_data);
            if (m_valid && m_ready) board.compare_totals(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("FAIL source_line_classifier");
        $finish;
    end

    // result side backpressure
    initial begin
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!full_rate && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!full_rate && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{text_byte: b, final_byte: last};
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
    endtask

    task automatic send_file();
        logic [7:0]       text [$];
        int               target;
        int               pick;
        int               n;
        int               k;
        logic [PAT_W-1:0] pat;
        logic [LEN_W-1:0] len;
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
        while (text.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                text.push_back(8'($urandom_range(33, 126)));
            end else if (pick < 38) begin
                text.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
            end else if (pick < 50) begin
                text.push_back(CHAR_NEWLINE);
            end else if (pick < 56) begin
                text.push_back(CHAR_QUOTE);
            end else if (pick < 60) begin
                text.push_back(CHAR_BACKSLASH);
            end else if (pick < 64) begin
                text.push_back(CHAR_SLASH);
            end else if (pick < 94) begin
                n = $urandom_range(0, 2);
                if (n == 0) begin
                    pat = board.regs.block_open_pattern;
                    len = board.regs.block_open_length;
                end else if (n == 1) begin
                    pat = board.regs.block_close_pattern;
                    len = board.regs.block_close_length;
                end else begin
                    pat = board.regs.line_comment_pattern;
                    len = board.regs.line_comment_length;
                end
                n = (len > PAT_BYTES) ? PAT_BYTES : int'(len);
                // broken delimiter: only a prefix
                if (pick >= 88 && n > 1) n = $urandom_range(1, n - 1);
                for (k = 0; k < n; k++) text.push_back(pat[8*k +: 8]);
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (k = 0; k < text.size(); k++) send_byte(text[k], k == text.size() - 1);
    endtask

    task automatic random_files(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) send_file();
    endtask

    task automatic go_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PAT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        board.set_reg(idx, data);
    endtask

    function automatic logic [PAT_W-1:0] pack_delim(input string s);
        logic [PAT_W-1:0] pat;
        int k;
        pat = '0;
        for (k = 0; k < s.len() && k < PAT_BYTES; k++) pat[8*k +: 8] = s[k];
        return pat;
    endfunction

    task automatic apply_setting(input logic [PAT_W-1:0] open_pat, input logic [LEN_W-1:0] open_len,
                                 input logic [PAT_W-1:0] close_pat,
                                 input logic [LEN_W-1:0] close_len,
                                 input logic [PAT_W-1:0] line_pat,
                                 input logic [LEN_W-1:0] line_len);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        write_reg(REG_BLOCK_OPEN_PATTERN, open_pat);
        write_reg(REG_BLOCK_OPEN_LENGTH, {noise[PAT_W-1:LEN_W], open_len});
        write_reg(REG_BLOCK_CLOSE_PATTERN, close_pat);
        write_reg(REG_BLOCK_CLOSE_LENGTH, {noise[PAT_W-2:LEN_W-1], close_len});
        write_reg(REG_LINE_COMMENT_PATTERN, line_pat);
        write_reg(REG_LINE_COMMENT_LENGTH, {noise[PAT_W+7:LEN_W+8], line_len});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        board = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed files under the reset delimiters
        send_text("\n");
        send_text("/");
        send_text("/*\n*/");
        send_text("\"\\\"\"x//");
        send_text("a/");
        send_text("x\n");
        send_text("\"\n\"");
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        go_quiet();

        random_files(PHASE_BYTES);
        go_quiet();

        // markup style delimiters, long receiver stall
        apply_setting(pack_delim("<!--"), 3'd4, pack_delim("-->"), 3'd3, pack_delim("#"), 3'd1);
        hold_request = 1'b1;
        random_files(PHASE_BYTES);
        go_quiet();

        // six byte delimiters, block patterns at the extremes
        apply_setting({PAT_W{1'b1}}, 3'd6, {PAT_W{1'b0}}, 3'd6,
                      PAT_W'({$urandom, $urandom}), 3'd6);
        random_files(PHASE_BYTES / 2);
        go_quiet();
        random_files(PHASE_BYTES / 2);
        go_quiet();

        // no comment syntax at all
        apply_setting(PAT_W'({$urandom, $urandom}), 3'd0, PAT_W'({$urandom, $urandom}), 3'd0,
                      PAT_W'({$urandom, $urandom}), 3'd0);
        write_reg(REG_SPARE, PAT_W'({$urandom, $urandom}));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        random_files(PHASE_BYTES);
        go_quiet();

        // oversized lengths and a block that never closes
        apply_setting(pack_delim("(*"), 3'd2, pack_delim("*)"), 3'd0, pack_delim("--"), 3'd7);
        random_files(PHASE_BYTES / 2);
        go_quiet();
        apply_setting(pack_delim("(*"), 3'd7, pack_delim("*)"), 3'd2, pack_delim("--"), 3'd2);
        random_files(PHASE_BYTES / 2);
        go_quiet();

        apply_setting(pack_delim("{"), 3'd1, pack_delim("}"), 3'd1, pack_delim(";"), 3'd1);
        random_files(PHASE_BYTES);
        go_quiet();

        // delimiters built from quote, newline and backslash
        apply_setting(pack_delim("\""), 3'd1, pack_delim("\n\n"), 3'd2, pack_delim("\\"), 3'd1);
        random_files(PHASE_BYTES);
        go_quiet();

        // back to c style, no idling on either side
        apply_setting(pack_delim("/*"), 3'd2, pack_delim("*/"), 3'd2, pack_delim("//"), 3'd2);
        full_rate = 1'b1;
        random_files(PHASE_BYTES);
        go_quiet();

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASS source_line_classifier");
        end else begin
            $display("FAIL source_line_classifier");
        end
        $finish;
    end

endmodule

// ===== source_line_classifier.f =====
+incdir+sv
sv/slc_pkg.sv
sv/slc_head_step.sv
sv/source_line_classifier.sv
sim/source_line_classifier_tb.sv
